// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the RTL file interval_set_merge_split.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/isms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isms_pkg
// Types, codes and constants of the interval set block.
// ----------------------------------------------------------------------------
package isms_pkg;

  localparam int MAX_INTERVALS_DEF = 64;

  localparam logic [1:0] FN_INSERT   = 2'd0;
  localparam logic [1:0] FN_ERASE    = 2'd1;
  localparam logic [1:0] FN_CONTAINS = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CMP,
    ACT_INS_NEW,
    ACT_INS_MERGE,
    ACT_SPLIT,
    ACT_CUT,
    ACT_SHIFT
  } act_t;

  typedef struct packed {
    act_t               act;
    logic               ins;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
  } ctl_t;

  // Contents of one cell
  typedef struct packed {
    logic signed [63:0] s;
    logic signed [63:0] e;
    logic               t;
  } ent_t;

  // Compare results of one cell
  typedef struct packed {
    logic b;
    logic hit;
    logic splt;
  } flg_t;

endpackage

// ----- src/isms_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isms_cell
// One table slot: holds an interval, compares it, shifts with its neighbours.
// ----------------------------------------------------------------------------
module isms_cell (
  input  logic            clk,
  input  logic            rst,
  input  isms_pkg::ctl_t  ctl,
  input  logic            occ,
  input  isms_pkg::ent_t  lft,
  input  logic            lft_b,
  input  logic            lft_at,
  input  isms_pkg::ent_t  rgt,
  output isms_pkg::ent_t  ent,
  output logic            at,
  output isms_pkg::flg_t  flg
);

  logic signed [63:0] s, s_next;
  logic signed [63:0] e, e_next;
  logic t, t_next;
  logic at_next;
  logic gt, gt_next;
  logic touch, slt, egt, zone;

  assign slt   = s < ctl.lo;
  assign egt   = e > ctl.hi;
  assign touch = occ && (s <= ctl.hi) && (ctl.lo <= e);
  assign flg.b    = occ && (e < ctl.lo);
  assign flg.hit  = occ && (s <= ctl.lo) && (ctl.lo <= e);
  assign flg.splt = touch && slt && egt;
  // removal zone: everything above the anchor, plus the anchor if marked
  assign zone = gt || (at && t);

  always_comb begin
    s_next  = s;
    e_next  = e;
    t_next  = t;
    at_next = at;
    gt_next = gt;
    unique case (ctl.act)
      isms_pkg::ACT_CMP: begin
        t_next  = touch;
        at_next = lft_b && !flg.b;
        gt_next = !lft_b;
      end
      isms_pkg::ACT_INS_NEW: begin
        if (at) begin
          s_next = ctl.lo;
          e_next = ctl.hi;
        end else if (gt) begin
          s_next = lft.s;
          e_next = lft.e;
          t_next = lft.t;
        end
      end
      isms_pkg::ACT_INS_MERGE: begin
        if (at) begin
          s_next = slt ? s : ctl.lo;
          e_next = egt ? e : ctl.hi;
          t_next = 1'b0;
        end
      end
      isms_pkg::ACT_SPLIT: begin
        if (at) begin
          e_next = ctl.lo;
          t_next = 1'b0;
        end else if (lft_at) begin
          s_next = ctl.hi;
          e_next = lft.e;
          t_next = 1'b0;
        end else if (gt) begin
          s_next = lft.s;
          e_next = lft.e;
          t_next = lft.t;
        end
      end
      isms_pkg::ACT_CUT: begin
        if (t) begin
          if (slt) begin
            e_next = ctl.lo;
            t_next = 1'b0;
          end else if (egt) begin
            s_next = ctl.hi;
            t_next = 1'b0;
          end
        end
      end
      isms_pkg::ACT_SHIFT: begin
        if (zone) begin
          s_next = rgt.s;
          e_next = rgt.e;
          t_next = rgt.t;
        end else if (at && ctl.ins && (rgt.e > e)) begin
          e_next = rgt.e;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    s <= s_next;
    e <= e_next;
    if (rst) begin
      t  <= 1'b0;
      at <= 1'b0;
      gt <= 1'b0;
    end else begin
      t  <= t_next;
      at <= at_next;
      gt <= gt_next;
    end
  end

  assign ent.s = s;
  assign ent.e = e;
  assign ent.t = t;

endmodule

// ----- src/interval_set_merge_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_merge_split
// Sorted table of disjoint closed intervals with insert/merge,
// erase/split and a right-inclusive contains query.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  cmd     | cmd_valid/cmd_ready  | func, lo, hi
//  res     | res_valid/res_ready  | found, status, stored_count
//
// Steps: accept, compare in every cell, edit, hand over the result; a query,
//   a rejected item, a fresh insert or a split needs no more than these.
// An insert that merges, or an erase that cuts, adds a shift phase for the
//   removed intervals; the left shift through the cell row moves one slot per cycle.
// Reset (rst, synchronous) empties the table at once; no clearing pass.
// The next item is accepted while a result still waits on res_ready; that
//   item is then held in its final step until the waiting result has gone.
// ----------------------------------------------------------------------------
module interval_set_merge_split #(
  parameter int MAX_INTERVALS = isms_pkg::MAX_INTERVALS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  logic [1:0]                           func,
  input  logic signed [63:0]                   lo,
  input  logic signed [63:0]                   hi,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic                                 found,
  output logic [1:0]                           status,
  output logic [$clog2(MAX_INTERVALS+1)-1:0]   stored_count
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_EDIT  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [1:0] op;
  logic signed [63:0] op_lo, op_hi;
  logic hit_r;
  logic [1:0] st, st_next;
  isms_pkg::act_t act;
  isms_pkg::ctl_t ctl;

  isms_pkg::ent_t ents [MAX_INTERVALS];
  isms_pkg::flg_t flgs [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] at_vec, t_vec, hit_vec, splt_vec;
  logic t_any, split_any, full, bad, is_ins, is_ers;

  // ---- row of cells; each sees its left and right neighbour ----
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    isms_pkg::ent_t lft_i, rgt_i;
    logic lft_b_i, lft_at_i;
    if (i == 0) begin : g_first
      assign lft_i    = '0;
      assign lft_b_i  = 1'b1;   // nothing lies left of slot 0
      assign lft_at_i = 1'b0;
    end else begin : g_mid
      assign lft_i    = ents[i-1];
      assign lft_b_i  = flgs[i-1].b;
      assign lft_at_i = at_vec[i-1];
    end
    if (i == MAX_INTERVALS - 1) begin : g_last
      assign rgt_i = '0;
    end else begin : g_inner
      assign rgt_i = ents[i+1];
    end
    isms_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .occ    (CW'(i) < count),
      .lft    (lft_i),
      .lft_b  (lft_b_i),
      .lft_at (lft_at_i),
      .rgt    (rgt_i),
      .ent    (ents[i]),
      .at     (at_vec[i]),
      .flg    (flgs[i])
    );
    assign t_vec[i]    = ents[i].t;
    assign hit_vec[i]  = flgs[i].hit;
    assign splt_vec[i] = flgs[i].splt;
  end

  assign t_any     = |t_vec;
  assign split_any = |splt_vec;
  assign is_ins    = op == isms_pkg::FN_INSERT;
  assign is_ers    = op == isms_pkg::FN_ERASE;
  // ordering rule differs: insert allows a point, erase does not
  assign bad  = (is_ins && (op_lo > op_hi)) || (is_ers && (op_lo >= op_hi));
  // only a fresh insert or a split grows the table
  assign full = (count == CW'(MAX_INTERVALS)) &&
                ((is_ins && !t_any) || (is_ers && split_any));

  assign ctl.act = act;
  assign ctl.lo  = op_lo;
  assign ctl.hi  = op_hi;
  assign ctl.ins = is_ins;

  always_comb begin
    state_next = state;
    count_next = count;
    st_next    = st;
    act        = isms_pkg::ACT_NONE;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_CMP;
      end
      S_CMP: begin
        act        = isms_pkg::ACT_CMP;
        st_next    = isms_pkg::ST_OK;
        state_next = S_EDIT;
      end
      S_EDIT: begin
        state_next = S_DONE;
        if (is_ins || is_ers) begin
          if (bad) begin
            st_next = isms_pkg::ST_BAD;
          end else if (full) begin
            st_next = isms_pkg::ST_FULL;
          end else if (is_ins && !t_any) begin
            act        = isms_pkg::ACT_INS_NEW;
            count_next = count + CW'(1);
          end else if (is_ins) begin
            act        = isms_pkg::ACT_INS_MERGE;
            state_next = S_SHIFT;
          end else if (split_any) begin
            act        = isms_pkg::ACT_SPLIT;
            count_next = count + CW'(1);
          end else begin
            act        = isms_pkg::ACT_CUT;
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // drop one marked interval per cycle until none is left
        if (t_any) begin
          act        = isms_pkg::ACT_SHIFT;
          count_next = count - CW'(1);
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    st <= st_next;
    if (cmd_valid && cmd_ready) begin
      op    <= func;
      op_lo <= lo;
      op_hi <= hi;
    end
    if (state == S_CMP) hit_r <= (op == isms_pkg::FN_CONTAINS) && (|hit_vec);
    if (state == S_DONE && (!res_valid || res_ready)) begin
      found        <= hit_r;
      status       <= st;
      stored_count <= count;
    end
  end

`include "assert_macros.svh"

  `CHK_IMP(a_count_cap, 1'b1, count <= CW'(MAX_INTERVALS), "table count above capacity")
  `CHK_IMP(a_one_anchor, state == S_EDIT, $onehot0(at_vec), "more than one anchor cell")
  `CHK_NXT(a_shift_dec, state == S_SHIFT && t_any, count == $past(count) - CW'(1), "shift lost count")

endmodule
